// ----- hdl/mandelbrot_escape_fixed_point_defines.svh -----
// ----------------------------------------------------------------------------
// mandelbrot escape engine assertion macros
// property shorthands for the escape engine datapath
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_FIXED_POINT_DEFINES_SVH
`define MANDELBROT_ESCAPE_FIXED_POINT_DEFINES_SVH

// same-cycle implication
`define MBE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// types, widths and fixed-point constants of the mandelbrot escape engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbe_pkg;

   localparam int FRAC_BITS = 28;

   localparam int PIX_W   = 11;
   localparam int DIM_W   = 12;
   localparam int CNT_W   = 16;
   localparam int SUM_W   = 48;
   localparam int CSR_W   = 16;
   localparam int CSR_A_W = 2;

   // dividend of the real coordinate: pixel * 3.5 in fixed point
   localparam int NUM_W     = PIX_W + 3 + FRAC_BITS - 1;
   localparam int REM_W     = DIM_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   // z and c registers, multiplier operands and squared terms
   localparam int Z_W  = NUM_W + 3;
   localparam int OP_W = FRAC_BITS + 3;
   localparam int P_W  = 2 * OP_W;
   localparam int SQ_W = FRAC_BITS + 4;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

   localparam logic signed [Z_W-1:0]  ONE_FX       = Z_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [Z_W-1:0]  TWO_FX       = Z_W'(64'sd2 <<< FRAC_BITS);
   localparam logic signed [Z_W-1:0]  FIVE_HALF_FX = Z_W'(64'sd5 <<< (FRAC_BITS - 1));
   localparam logic signed [SQ_W:0]   FOUR_FX      = (SQ_W + 1)'(64'sd4 <<< FRAC_BITS);

   localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(128);
   localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(128);
   localparam logic [CNT_W-1:0] LIMIT_RST  = CNT_W'(100);

   typedef enum logic [CSR_A_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ITER_LIMIT   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SETUP,
      ST_MUL,
      ST_UPD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic setup;
      logic mul;
      logic upd;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic limit_hit;
      logic bound_esc;
      logic mag_esc;
   } dpath_sts_type;

endpackage

// ----- hdl/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbe_ctrl
// sequencer of the escape engine: divide, iterate, deliver one result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_ctrl
   import mbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dpath_sts_type sts,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.limit_hit || sts.bound_esc) state_in = ST_FINISH;
            else                                state_in = ST_UPD;
         end
         ST_UPD: begin
            if (sts.mag_esc) state_in = ST_FINISH;
            else             state_in = ST_MUL;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = !(sts.limit_hit || sts.bound_esc);
         end
         ST_UPD: begin
            cmd.upd = !sts.mag_esc;
         end
         ST_FINISH: begin
            cmd.finish = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hdl/mbe_dpath.sv -----
// ----------------------------------------------------------------------------
// mbe_dpath
// config registers, coordinate dividers, z iteration and checksum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_fixed_point_defines.svh"

module mbe_dpath
   import mbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic [PIX_W-1:0]   pixel_x,
   input  logic [PIX_W-1:0]   pixel_y,
   input  logic               clear_sum,
   input  ctrl_cmd_type       cmd,
   output dpath_sts_type      sts,
   output logic [CNT_W-1:0]   escape_count,
   output logic [SUM_W-1:0]   running_checksum
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [CNT_W-1:0] limit_ff;

   logic [NUM_W-1:0]     num_re_ff, num_re_in, num_im_ff, num_im_in;
   logic [REM_W-1:0]     rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [DIM_W-1:0]     den_re_ff, den_im_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 clear_ff;

   logic signed [Z_W-1:0]  cre_ff, cim_ff, zr_ff, zr_in, zi_ff, zi_in;
   logic signed [SQ_W-1:0] rr_ff, ii_ff, ri_ff;
   logic signed [OP_W-1:0] op_r, op_i;
   logic signed [P_W-1:0]  prod_rr, prod_ii, prod_ri;
   logic signed [SQ_W:0]   mag;
   logic [CNT_W-1:0]       n_ff;

   logic [SUM_W-1:0] sum_ff, sum_in, sum_base;
   logic [SUM_W:0]   sum_total;
   logic [CNT_W-1:0] count_ff;

   logic [REM_W-1:0] trial_re, trial_im;
   logic             bit_re, bit_im;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         limit_ff  <= LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_ITER_LIMIT:   limit_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // restoring dividers, one quotient bit per cycle each
   assign trial_re = {rem_re_ff[REM_W-2:0], num_re_ff[NUM_W-1]};
   assign trial_im = {rem_im_ff[REM_W-2:0], num_im_ff[NUM_W-1]};
   assign bit_re   = trial_re >= {1'b0, den_re_ff};
   assign bit_im   = trial_im >= {1'b0, den_im_ff};

   always_comb begin
      num_re_in  = num_re_ff;
      num_im_in  = num_im_ff;
      rem_re_in  = rem_re_ff;
      rem_im_in  = rem_im_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.load) begin
         // pixel * 3.5 as pixel * (4 - 0.5), pixel * 2 as a shift
         num_re_in  = (NUM_W'(pixel_x) << (FRAC_BITS + 2))
                    - (NUM_W'(pixel_x) << (FRAC_BITS - 1));
         num_im_in  = NUM_W'(pixel_y) << (FRAC_BITS + 1);
         rem_re_in  = '0;
         rem_im_in  = '0;
         div_cnt_in = DIV_LAST;
      end else if (cmd.div_step) begin
         num_re_in  = {num_re_ff[NUM_W-2:0], bit_re};
         num_im_in  = {num_im_ff[NUM_W-2:0], bit_im};
         rem_re_in  = bit_re ? trial_re - {1'b0, den_re_ff} : trial_re;
         rem_im_in  = bit_im ? trial_im - {1'b0, den_im_ff} : trial_im;
         div_cnt_in = div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_re_ff  <= num_re_in;
      num_im_ff  <= num_im_in;
      rem_re_ff  <= rem_re_in;
      rem_im_ff  <= rem_im_in;
      div_cnt_ff <= div_cnt_in;
      if (cmd.load) begin
         den_re_ff <= (width_ff  == '0) ? DIM_W'(1) : width_ff;
         den_im_ff <= (height_ff == '0) ? DIM_W'(1) : height_ff;
         clear_ff  <= clear_sum;
      end
   end

   // z iteration: products are registered, sum and compare follow in the next cycle
   assign op_r    = zr_ff[OP_W-1:0];
   assign op_i    = zi_ff[OP_W-1:0];
   assign prod_rr = P_W'(op_r) * P_W'(op_r);
   assign prod_ii = P_W'(op_i) * P_W'(op_i);
   assign prod_ri = P_W'(op_r) * P_W'(op_i);
   assign mag     = (SQ_W + 1)'(rr_ff) + (SQ_W + 1)'(ii_ff);

   always_comb begin
      zr_in = Z_W'(rr_ff) - Z_W'(ii_ff) + cre_ff;
      zi_in = (Z_W'(ri_ff) <<< 1) + cim_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         cre_ff <= signed'(Z_W'(num_re_ff)) - FIVE_HALF_FX;
         cim_ff <= signed'(Z_W'(num_im_ff)) - ONE_FX;
         zr_ff  <= '0;
         zi_ff  <= '0;
         n_ff   <= '0;
      end else if (cmd.upd) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
         n_ff  <= n_ff + 1'b1;
      end
      if (cmd.mul) begin
         // floor shift of a two's complement product is a bit select
         rr_ff <= signed'(prod_rr[FRAC_BITS +: SQ_W]);
         ii_ff <= signed'(prod_ii[FRAC_BITS +: SQ_W]);
         ri_ff <= signed'(prod_ri[FRAC_BITS +: SQ_W]);
      end
   end

   assign sts.div_last  = div_cnt_ff == '0;
   assign sts.limit_hit = n_ff >= limit_ff;
   assign sts.bound_esc = (zr_ff > TWO_FX) || (zr_ff < -TWO_FX)
                       || (zi_ff > TWO_FX) || (zi_ff < -TWO_FX);
   assign sts.mag_esc   = mag > FOUR_FX;

   // saturating checksum
   assign sum_base  = clear_ff ? '0 : sum_ff;
   assign sum_total = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(n_ff);
   assign sum_in    = sum_total[SUM_W] ? '1 : sum_total[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.finish) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         count_ff <= n_ff;
      end
   end

   assign escape_count     = count_ff;
   assign running_checksum = sum_ff;

   `MBE_ASSERT_SAME(a_mul_below_limit, clock, reset, cmd.mul, n_ff < limit_ff,
      "iteration started at or past the limit")
   `MBE_ASSERT_SAME(a_mul_in_range, clock, reset, cmd.mul,
      (zr_ff <= TWO_FX) && (zr_ff >= -TWO_FX) && (zi_ff <= TWO_FX) && (zi_ff >= -TWO_FX),
      "multiplier operand outside two")
   `MBE_ASSERT_NEXT(a_sum_monotone, clock, reset, cmd.finish && !clear_ff,
      sum_ff >= $past(sum_ff), "checksum decreased without clear")

endmodule

// ----- hdl/mandelbrot_escape_fixed_point.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_fixed_point
// Each request item carries one pixel; the block maps it to c with real part
// x*3.5/width-2.5 and imaginary part y*2/height-1 in signed Q.28 (truncating
// divisions), iterates z = z*z + c until |z|^2 exceeds 4.0, a coordinate of z
// exceeds two or the iteration limit is reached, and returns the count with a
// saturating running checksum of counts, cleared by the request's tuser flag.
// An item passes through the accept, the shift-subtract coordinate dividers,
// the setup of c and z, then iterations of the three squarings followed by the
// z update and magnitude compare, the final check and the load of the output
// register. A new item is accepted while the previous result still waits in
// the output register; that item then holds in its last cycle until the result
// is taken. Width, height and limit are written through the csr port; the user
// must write them only while the block is idle, which the block itself does
// not enforce. A width or height of zero acts as one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_fixed_point
   import mbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,   // pixel_x, pixel_y, zero pad
   input  logic               req_tuser,   // clear_sum
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,   // escape_count, running_checksum
   input  logic               csr_we,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]   csr_wdata
);

   ctrl_cmd_type     cmd;
   dpath_sts_type    sts;
   logic [CNT_W-1:0] escape_count;
   logic [SUM_W-1:0] running_checksum;

   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mbe_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .pixel_x          (req_tdata[PIX_W-1:0]),
      .pixel_y          (req_tdata[2*PIX_W-1:PIX_W]),
      .clear_sum        (req_tuser),
      .cmd              (cmd),
      .sts              (sts),
      .escape_count     (escape_count),
      .running_checksum (running_checksum)
   );

   assign rsp_tdata = {running_checksum, escape_count};

endmodule
